@@ rtl/assert_macros.svh @@
// assertion helper macros for the p-256 montgomery multiplier
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/mmp_pkg.sv @@
// shared types and constants for the p-256 montgomery multiplier
// no dependencies; used by mmp_front, mmp_back and the top level
package mmp_pkg;

    localparam int LIMB_W      = 64;
    localparam int LIMBS       = 4;
    localparam int SLOT_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int ACC_W       = 322;

    localparam logic [255:0] P256 =
        256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFF;

    typedef struct packed {
        logic [LIMB_W-1:0] a_limb;
        logic [LIMB_W-1:0] b_limb;
        logic [SLOT_W-1:0] slot;
    } t_limb_item;

endpackage

@@ rtl/mmp_front.sv @@
// front part: accepts operand limbs, tags each with its slot, queues them
// depends on mmp_pkg
module mmp_front #(
    parameter int P_DEPTH = mmp_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [mmp_pkg::LIMB_W-1:0] i_a_limb,
    input  logic [mmp_pkg::LIMB_W-1:0] i_b_limb,
    output logic                       o_vld,
    output mmp_pkg::t_limb_item        o_item,
    input  logic                       i_take
);
    import mmp_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_limb_item        r_mem [P_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_slot;
    logic              w_wr, w_rd;

    assign full   = (r_cnt == CNT_W'(P_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rd];
    assign w_wr   = push && !full;
    assign w_rd   = i_take && o_vld;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= '{a_limb: i_a_limb, b_limb: i_b_limb, slot: r_slot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_slot <= '0;
        end else begin
            if (w_wr) begin
                r_wr   <= (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
                r_slot <= r_slot + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/mmp_back.sv @@
// back part: operand store, montgomery rounds on a 32x32 multiplier, result buffer
// depends on mmp_pkg
module mmp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  mmp_pkg::t_limb_item        i_item,
    output logic                       o_take,
    output logic                       empty,
    input  logic                       pop,
    output logic [mmp_pkg::LIMB_W-1:0] o_result_limb,
    output logic [mmp_pkg::SLOT_W-1:0] o_limb_position,
    output logic                       o_last_limb
);
    import mmp_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;

    logic [2:0]        r_state;
    logic [LIMB_W-1:0] r_a [LIMBS];
    logic [LIMB_W-1:0] r_b [LIMBS];
    logic [SLOT_W-1:0] r_round;
    logic [4:0]        r_k;
    logic [2:0]        r_rstep;
    logic [63:0]       r_pp;
    logic [3:0]        r_sh;
    logic [ACC_W-1:0]  r_acc;
    logic [63:0]       r_m;
    logic [LIMB_W-1:0] r_res [LIMBS];
    logic [SLOT_W-1:0] r_opos;
    logic              r_ovld;

    logic [31:0]       w_x, w_y;
    logic [LIMB_W-1:0] w_aw, w_bw;
    logic [ACC_W-1:0]  w_pp_ext, w_m_ext;
    logic [256:0]      w_diff;
    logic              w_take_diff;

    assign o_take = (r_state == S_LOAD) && i_vld;

    // partial product select: k = {limb j, high half of a, high half of b}
    assign w_aw = r_a[r_round];
    assign w_bw = r_b[r_k[3:2]];
    assign w_x  = r_k[1] ? w_aw[63:32] : w_aw[31:0];
    assign w_y  = r_k[0] ? w_bw[63:32] : w_bw[31:0];

    assign w_pp_ext = {{(ACC_W-64){1'b0}}, r_pp};
    assign w_m_ext  = {{(ACC_W-64){1'b0}}, r_m};

    // final conditional subtraction
    assign w_diff      = {1'b0, r_acc[255:0]} - {1'b0, P256};
    assign w_take_diff = (r_acc[ACC_W-1:256] != '0) || !w_diff[256];

    assign empty           = !r_ovld;
    assign o_result_limb   = r_res[r_opos];
    assign o_limb_position = r_opos;
    assign o_last_limb     = (r_opos == SLOT_W'(LIMBS - 1));

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_a[i_item.slot] <= i_item.a_limb;
            r_b[i_item.slot] <= i_item.b_limb;
        end
        if (r_state == S_MUL && r_k < 5'd16) begin
            r_pp <= {32'd0, w_x} * {32'd0, w_y};
            r_sh <= 4'({r_k[3:2], 1'b0}) + 4'(r_k[1]) + 4'(r_k[0]);
        end
        if (r_state == S_RED && r_rstep == 3'd0) begin
            r_m <= r_acc[63:0];
        end
        if (r_state == S_FIN && !r_ovld) begin
            for (int j = 0; j < LIMBS; j++) begin
                r_res[j] <= w_take_diff ? w_diff[64*j +: 64] : r_acc[64*j +: 64];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_round <= '0;
            r_k     <= '0;
            r_rstep <= '0;
            r_acc   <= '0;
            r_opos  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (o_take && i_item.slot == SLOT_W'(LIMBS - 1)) begin
                        r_state <= S_MUL;
                        r_round <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                    end
                end
                S_MUL: begin
                    if (r_k != 5'd0) begin
                        r_acc <= r_acc + (w_pp_ext << {r_sh, 5'd0});
                    end
                    if (r_k == 5'd16) begin
                        r_state <= S_RED;
                        r_rstep <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_RED: begin
                    // acc + m*p with p = 2^256 - 2^224 + 2^192 + 2^96 - 1, adds first
                    case (r_rstep)
                        3'd0: r_acc <= r_acc + ({{(ACC_W-64){1'b0}}, r_acc[63:0]} << 256);
                        3'd1: r_acc <= r_acc + (w_m_ext << 192);
                        3'd2: r_acc <= r_acc + (w_m_ext << 96);
                        3'd3: r_acc <= r_acc - (w_m_ext << 224);
                        default: r_acc <= (r_acc - w_m_ext) >> 64;
                    endcase
                    if (r_rstep == 3'd4) begin
                        r_k     <= '0;
                        r_round <= r_round + 1'b1;
                        r_state <= (r_round == SLOT_W'(LIMBS - 1)) ? S_FIN : S_MUL;
                    end else begin
                        r_rstep <= r_rstep + 1'b1;
                    end
                end
                S_FIN: begin
                    if (!r_ovld) begin
                        r_ovld  <= 1'b1;
                        r_opos  <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            if (pop && r_ovld) begin
                r_opos <= r_opos + 1'b1;
                if (r_opos == SLOT_W'(LIMBS - 1)) begin
                    r_ovld <= 1'b0;
                end
            end
        end
    end

endmodule

@@ rtl/montgomery_mul_p256.sv @@
// top level of the p-256 montgomery multiplier (a*b*2^-256 mod p)
// depends on mmp_pkg, mmp_front, mmp_back and assert_macros.svh
//
// channel  direction  handshake           payload
// input    in         push / full         i_a_limb, i_b_limb (one limb each, lsb first)
// result   out        empty / pop         o_result_limb, o_limb_position, o_last_limb
//
// datapath: after the fourth limb is taken by the back part, results show once four rounds
//   have run, each of 16 partial products on one 32x32 multiplier plus one drain step and
//   5 shift-add reduction steps, then a final conditional subtraction; no limbs are taken meanwhile
// reset: synchronous active low; clears queue pointers, slot count and result valid flag
// stalls: the front queue keeps taking limbs until full while the back part computes or waits
//   on a full result buffer; results stay on the ports until popped
`include "assert_macros.svh"
module montgomery_mul_p256 #(
    parameter int P_QUEUE_DEPTH = mmp_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [mmp_pkg::LIMB_W-1:0] i_a_limb,
    input  logic [mmp_pkg::LIMB_W-1:0] i_b_limb,
    output logic                       empty,
    input  logic                       pop,
    output logic [mmp_pkg::LIMB_W-1:0] o_result_limb,
    output logic [mmp_pkg::SLOT_W-1:0] o_limb_position,
    output logic                       o_last_limb
);
    import mmp_pkg::*;

    // limb queue between front and back
    logic       w_vld;
    logic       w_take;
    t_limb_item w_item;

    // front: takes transfers and tags each limb pair with its slot in the operand
    mmp_front #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_a_limb (i_a_limb),
        .i_b_limb (i_b_limb),
        .o_vld    (w_vld),
        .o_item   (w_item),
        .i_take   (w_take)
    );

    // back: operand store, montgomery rounds, conditional subtract, result buffer
    mmp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (w_vld),
        .i_item          (w_item),
        .o_take          (w_take),
        .empty           (empty),
        .pop             (pop),
        .o_result_limb   (o_result_limb),
        .o_limb_position (o_limb_position),
        .o_last_limb     (o_last_limb)
    );

    // last flag marks exactly the top limb
    `ASSERT_IMPLIES(a_last_pos, i_clk, i_rst_n, !empty,
        o_last_limb == (o_limb_position == SLOT_W'(LIMBS - 1)))
    // a popped limb that is not the last is followed by the next position
    `ASSERT_NEXT(a_pos_step, i_clk, i_rst_n, pop && !empty && !o_last_limb,
        !empty && o_limb_position == $past(o_limb_position) + 1'b1)
    // the back part only takes from a non-empty queue
    `ASSERT_IMPLIES(a_take_vld, i_clk, i_rst_n, w_take, w_vld)

endmodule
